// ===== hdl/gnss_binary_frame_parser_unit_assert.svh =====
// assertion macros for the checker of the frame parser
`ifndef GNSS_BINARY_FRAME_PARSER_UNIT_ASSERT_SVH
`define GNSS_BINARY_FRAME_PARSER_UNIT_ASSERT_SVH

// clocked assertion, disabled while reset is low
`define GBFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the usual clock and reset names
`define GBFP_ASSERT_STD(lbl, prop, msg) `GBFP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/gbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfp_pkg
// Types, codes and constants shared by the binary frame parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gbfp_pkg;

  // frame header bytes
  localparam logic [7:0] SYNC_A    = 8'hB5;
  localparam logic [7:0] SYNC_B    = 8'h62;
  localparam logic [7:0] CLASS_NAV = 8'h01;
  localparam logic [7:0] ID_POS    = 8'h02;
  localparam logic [7:0] ID_SOL    = 8'h06;
  localparam logic [7:0] ID_VEL    = 8'h12;

  // message types
  localparam logic [1:0] TYPE_POS = 2'd0;
  localparam logic [1:0] TYPE_SOL = 2'd1;
  localparam logic [1:0] TYPE_VEL = 2'd2;
  localparam int unsigned NUM_TYPES = 3;

  // store sizes per message type
  localparam logic [5:0] POSITION_BYTES = 6'd28;
  localparam logic [5:0] SOLUTION_BYTES = 6'd52;
  localparam logic [5:0] VELOCITY_BYTES = 6'd36;

  localparam logic [15:0] TIMEOUT_RELOAD_RST = 16'd2000;

  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BAD_CK  = 3'd2,
    KIND_DROPPED = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    TS_INVALID   = 2'd0,
    TS_NEW       = 2'd1,
    TS_PROCESSED = 2'd2
  } ts_e;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SYNC1 = 9'b000000010,
    ST_SYNC2 = 9'b000000100,
    ST_CLASS = 9'b000001000,
    ST_LEN1  = 9'b000010000,
    ST_LEN2  = 9'b000100000,
    ST_DATA  = 9'b001000000,
    ST_CKA   = 9'b010000000,
    ST_CKB   = 9'b100000000
  } state_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [1:0] msg_type;
    logic [5:0] byte_offset;
    logic [7:0] data_byte;
    logic       snapshot_ready;
    logic [2:0] new_mask;
  } result_t;

  function automatic logic [5:0] store_size(input logic [1:0] msg_type);
    logic [5:0] size;
    case (msg_type)
      TYPE_POS: size = POSITION_BYTES;
      TYPE_SOL: size = SOLUTION_BYTES;
      TYPE_VEL: size = VELOCITY_BYTES;
      default:  size = 6'd0;
    endcase
    return size;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gbfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// gbfp_in_stage
// Input register: holds one accepted transaction until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfp_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire gbfp_pkg::item_t item_i,
  input  wire logic           advance_i,
  output logic                item_valid_o,
  output gbfp_pkg::item_t     item_o
);

  logic            valid_q;
  gbfp_pkg::item_t item_q;

  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gbfp_core.sv =====
// ----------------------------------------------------------------------------
// gbfp_core
// Frame state machine, Fletcher-8 sums, type status and link watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfp_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            step_i,
  input  wire gbfp_pkg::item_t item_i,
  output gbfp_pkg::result_t    result_o
);

  gbfp_pkg::state_e state_q, state_d;
  logic [7:0]       sum_a_q, sum_a_d;
  logic [7:0]       sum_b_q, sum_b_d;
  logic [15:0]      bytes_left_q, bytes_left_d;
  logic [1:0]       cur_type_q, cur_type_d;
  logic [5:0]       write_pos_q, write_pos_d;
  gbfp_pkg::ts_e    status_q [gbfp_pkg::NUM_TYPES];
  gbfp_pkg::ts_e    status_d [gbfp_pkg::NUM_TYPES];
  logic [15:0]      count_q, count_d;
  logic [15:0]      reload_q;

  logic [7:0]       c;
  logic [7:0]       add_a;
  logic [7:0]       add_b;
  logic             cur_in_range;
  logic             cur_is_new;
  logic             snap_check;
  logic             all_new;

  assign c            = item_i.rx_byte;
  assign add_a        = sum_a_q + c;
  assign add_b        = sum_b_q + add_a;
  assign cur_in_range = (cur_type_q != 2'd3);
  assign cur_is_new   = cur_in_range && (status_q[cur_type_q] == gbfp_pkg::TS_NEW);

  always_comb begin
    state_d      = state_q;
    sum_a_d      = sum_a_q;
    sum_b_d      = sum_b_q;
    bytes_left_d = bytes_left_q;
    cur_type_d   = cur_type_q;
    write_pos_d  = write_pos_q;
    count_d      = count_q;
    status_d     = status_q;
    snap_check   = 1'b0;
    result_o     = '0;
    result_o.kind = gbfp_pkg::KIND_WRITE;

    if (step_i) begin
      if (item_i.op) begin
        // timer tick: watchdog counts down only while armed
        if (count_q != 16'd0) begin
          count_d = count_q - 16'd1;
          if (count_q == 16'd1) begin
            state_d         = gbfp_pkg::ST_IDLE;
            result_o.valid  = 1'b1;
            result_o.kind   = gbfp_pkg::KIND_TIMEOUT;
          end
        end
      end else begin
        case (state_q)
          gbfp_pkg::ST_IDLE: begin
            state_d = (c == gbfp_pkg::SYNC_A) ? gbfp_pkg::ST_SYNC1 : gbfp_pkg::ST_IDLE;
          end
          gbfp_pkg::ST_SYNC1: begin
            state_d = (c == gbfp_pkg::SYNC_B) ? gbfp_pkg::ST_SYNC2 : gbfp_pkg::ST_IDLE;
          end
          gbfp_pkg::ST_SYNC2: begin
            state_d = (c == gbfp_pkg::CLASS_NAV) ? gbfp_pkg::ST_CLASS : gbfp_pkg::ST_IDLE;
          end
          gbfp_pkg::ST_CLASS: begin
            if (c == gbfp_pkg::ID_POS || c == gbfp_pkg::ID_SOL || c == gbfp_pkg::ID_VEL) begin
              if (c == gbfp_pkg::ID_POS) begin
                cur_type_d = gbfp_pkg::TYPE_POS;
              end else if (c == gbfp_pkg::ID_SOL) begin
                cur_type_d = gbfp_pkg::TYPE_SOL;
              end else begin
                cur_type_d = gbfp_pkg::TYPE_VEL;
              end
              // sums start over class and id
              sum_a_d = gbfp_pkg::CLASS_NAV + c;
              sum_b_d = gbfp_pkg::CLASS_NAV + sum_a_d;
              state_d = gbfp_pkg::ST_LEN1;
            end else begin
              state_d = gbfp_pkg::ST_IDLE;
            end
          end
          gbfp_pkg::ST_LEN1: begin
            bytes_left_d = {8'd0, c};
            sum_a_d      = add_a;
            sum_b_d      = add_b;
            state_d      = gbfp_pkg::ST_LEN2;
          end
          gbfp_pkg::ST_LEN2: begin
            bytes_left_d = {c, bytes_left_q[7:0]};
            sum_a_d      = add_a;
            sum_b_d      = add_b;
            if (cur_is_new) begin
              // previous data of this type not yet consumed
              snap_check         = 1'b1;
              state_d            = gbfp_pkg::ST_IDLE;
              result_o.valid     = 1'b1;
              result_o.kind      = gbfp_pkg::KIND_DROPPED;
              result_o.msg_type  = cur_type_q;
            end else begin
              if (cur_in_range) begin
                status_d[cur_type_q] = gbfp_pkg::TS_INVALID;
              end
              write_pos_d = 6'd0;
              state_d     = ({c, bytes_left_q[7:0]} == 16'd0) ? gbfp_pkg::ST_CKA
                                                               : gbfp_pkg::ST_DATA;
            end
          end
          gbfp_pkg::ST_DATA: begin
            if (write_pos_q < gbfp_pkg::store_size(cur_type_q)) begin
              result_o.valid       = 1'b1;
              result_o.kind        = gbfp_pkg::KIND_WRITE;
              result_o.msg_type    = cur_type_q;
              result_o.byte_offset = write_pos_q;
              result_o.data_byte   = c;
              write_pos_d          = write_pos_q + 6'd1;
            end
            sum_a_d      = add_a;
            sum_b_d      = add_b;
            bytes_left_d = bytes_left_q - 16'd1;
            if (bytes_left_q == 16'd1) begin
              state_d = gbfp_pkg::ST_CKA;
            end
          end
          gbfp_pkg::ST_CKA: begin
            if (c == sum_a_q) begin
              state_d = gbfp_pkg::ST_CKB;
            end else begin
              if (cur_in_range) begin
                status_d[cur_type_q] = gbfp_pkg::TS_INVALID;
              end
              state_d           = gbfp_pkg::ST_IDLE;
              result_o.valid    = 1'b1;
              result_o.kind     = gbfp_pkg::KIND_BAD_CK;
              result_o.msg_type = cur_type_q;
            end
          end
          gbfp_pkg::ST_CKB: begin
            state_d           = gbfp_pkg::ST_IDLE;
            result_o.valid    = 1'b1;
            result_o.msg_type = cur_type_q;
            if (c == sum_b_q) begin
              if (cur_in_range) begin
                status_d[cur_type_q] = gbfp_pkg::TS_NEW;
              end
              snap_check    = 1'b1;
              count_d       = reload_q;
              result_o.kind = gbfp_pkg::KIND_GOOD;
            end else begin
              if (cur_in_range) begin
                status_d[cur_type_q] = gbfp_pkg::TS_INVALID;
              end
              result_o.kind = gbfp_pkg::KIND_BAD_CK;
            end
          end
          default: begin
            state_d = gbfp_pkg::ST_IDLE;
          end
        endcase
      end
    end

    // all three types fresh: hand them over as one set
    all_new = (status_d[0] == gbfp_pkg::TS_NEW) && (status_d[1] == gbfp_pkg::TS_NEW) &&
              (status_d[2] == gbfp_pkg::TS_NEW);
    if (snap_check && all_new) begin
      for (int i = 0; i < gbfp_pkg::NUM_TYPES; i++) begin
        status_d[i] = gbfp_pkg::TS_PROCESSED;
      end
      result_o.snapshot_ready = 1'b1;
    end

    for (int i = 0; i < gbfp_pkg::NUM_TYPES; i++) begin
      result_o.new_mask[i] = (status_d[i] == gbfp_pkg::TS_NEW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gbfp_pkg::ST_IDLE;
      sum_a_q      <= 8'd0;
      sum_b_q      <= 8'd0;
      bytes_left_q <= 16'd0;
      cur_type_q   <= 2'd0;
      write_pos_q  <= 6'd0;
      count_q      <= 16'd0;
      reload_q     <= gbfp_pkg::TIMEOUT_RELOAD_RST;
      for (int i = 0; i < gbfp_pkg::NUM_TYPES; i++) begin
        status_q[i] <= gbfp_pkg::TS_INVALID;
      end
    end else begin
      state_q      <= state_d;
      sum_a_q      <= sum_a_d;
      sum_b_q      <= sum_b_d;
      bytes_left_q <= bytes_left_d;
      cur_type_q   <= cur_type_d;
      write_pos_q  <= write_pos_d;
      count_q      <= count_d;
      status_q     <= status_d;
      if (cfg_we_i) begin
        reload_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gbfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// gbfp_out_stage
// Result register: holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfp_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gbfp_pkg::result_t result_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output gbfp_pkg::result_t      result_o
);

  logic              valid_q;
  gbfp_pkg::result_t result_q;

  // the register can take a new result when empty or being drained
  assign advance_o   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && result_i.valid) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gnss_binary_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_unit
// Binary navigation frame parser with Fletcher-8 check and link watchdog.
// ----------------------------------------------------------------------------
// Takes one transaction (received byte or timer tick) per clock cycle. An
// accepted transaction is held in the input register and parsed there by the
// state machine; its result, if any, is registered in the result register,
// which drives out_valid_o. The rate is set by the single pass through the
// parser state update, so the block sustains one transaction per cycle for as
// long as out_ready_i is high. timeout_reload is to be written by the user
// through cfg_we_i and cfg_wdata_i while the block is idle; the block itself
// does not enforce this. A value of zero leaves the watchdog disarmed after a good frame.
`default_nettype none

module gnss_binary_frame_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [1:0]       msg_type_o,
  output logic [5:0]       byte_offset_o,
  output logic [7:0]       data_byte_o,
  output logic             snapshot_ready_o,
  output logic [2:0]       new_mask_o
);

  gbfp_pkg::item_t   item_in;
  gbfp_pkg::item_t   item_q;
  logic              item_valid;
  logic              advance;
  gbfp_pkg::result_t result_d;
  gbfp_pkg::result_t result_q;

  assign item_in.op      = op_i;
  assign item_in.rx_byte = rx_byte_i;

  gbfp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (item_in),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item_q)
  );

  gbfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (item_valid && advance),
    .item_i      (item_q),
    .result_o    (result_d)
  );

  gbfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result_d),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_q)
  );

  assign kind_o           = result_q.kind;
  assign msg_type_o       = result_q.msg_type;
  assign byte_offset_o    = result_q.byte_offset;
  assign data_byte_o      = result_q.data_byte;
  assign snapshot_ready_o = result_q.snapshot_ready;
  assign new_mask_o       = result_q.new_mask;

endmodule

`default_nettype wire

// ===== hdl/gbfp_checker.sv =====
// ----------------------------------------------------------------------------
// gbfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gnss_binary_frame_parser_unit_assert.svh"

module gbfp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] kind_o,
  input wire logic [1:0] msg_type_o,
  input wire logic [5:0] byte_offset_o,
  input wire logic [7:0] data_byte_o,
  input wire logic       snapshot_ready_o,
  input wire logic [2:0] new_mask_o
);

  // a stalled result transaction holds
  `GBFP_ASSERT_STD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(byte_offset_o) && $stable(data_byte_o) && $stable(new_mask_o), "stalled result changed")

  // a snapshot takes all three types, only on frame good or dropped
  `GBFP_ASSERT_STD(a_snap_clears, out_valid_o && snapshot_ready_o |-> new_mask_o == 3'd0 && (kind_o == gbfp_pkg::KIND_GOOD || kind_o == gbfp_pkg::KIND_DROPPED), "snapshot without clear")

  // only writes carry offset and data
  `GBFP_ASSERT_STD(a_status_zero, out_valid_o && kind_o != gbfp_pkg::KIND_WRITE |-> byte_offset_o == 6'd0 && data_byte_o == 8'd0, "status result carries payload")

  // a frame reported good leaves its type marked new unless taken as a set
  `GBFP_ASSERT_STD(a_good_new, out_valid_o && kind_o == gbfp_pkg::KIND_GOOD && !snapshot_ready_o |-> new_mask_o[msg_type_o] == 1'b1, "good frame not marked new")

  // watchdog results are plain
  `GBFP_ASSERT_STD(a_timeout_plain, out_valid_o && kind_o == gbfp_pkg::KIND_TIMEOUT |-> msg_type_o == 2'd0 && !snapshot_ready_o, "timeout with type or snapshot")

endmodule

bind gnss_binary_frame_parser_unit gbfp_checker u_gbfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .kind_o           (kind_o),
  .msg_type_o       (msg_type_o),
  .byte_offset_o    (byte_offset_o),
  .data_byte_o      (data_byte_o),
  .snapshot_ready_o (snapshot_ready_o),
  .new_mask_o       (new_mask_o)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gnss_binary_frame_parser_unit. Feeds receive bytes
// and timer ticks, mostly well-formed NAV frames with random payload, some
// broken headers, bad checksums, abandoned frames and watchdog timeouts. A
// model of the parser predicts every result transaction and a scoreboard
// compares it field by field as the block delivers it.
// ----------------------------------------------------------------------------
module testbench;
  import gbfp_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] msg_type;
    logic [5:0] byte_offset;
    logic [7:0] data_byte;
    logic       snapshot_ready;
    logic [2:0] new_mask;
  } parse_event_t;

  typedef enum int {FLAW_NONE, FLAW_CKA, FLAW_CKB} frame_flaw_e;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 100;

  class parser_scoreboard;
    state_e       pstate;
    logic [7:0]   sum_a, sum_b;
    logic [15:0]  bytes_left, reload, watch_count;
    logic [1:0]   cur_type;
    logic [5:0]   write_pos;
    ts_e          status [3];
    logic [5:0]   store_limit [3];
    parse_event_t expected_events [$];
    int           errors;

    function new();
      pstate = ST_IDLE;
      sum_a = '0;
      sum_b = '0;
      bytes_left = '0;
      reload = TIMEOUT_RELOAD_RST;
      watch_count = '0;
      cur_type = '0;
      write_pos = '0;
      foreach (status[i]) status[i] = TS_INVALID;
      store_limit[TYPE_POS] = POSITION_BYTES;
      store_limit[TYPE_SOL] = SOLUTION_BYTES;
      store_limit[TYPE_VEL] = VELOCITY_BYTES;
      errors = 0;
    endfunction

    function void fold_checksum(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function logic [2:0] fresh_mask();
      logic [2:0] m;
      foreach (status[i]) m[i] = (status[i] == TS_NEW);
      return m;
    endfunction

    // all three fresh at once: hand them over as one set
    function logic take_snapshot();
      if (fresh_mask() != 3'b111) return 1'b0;
      foreach (status[i]) status[i] = TS_PROCESSED;
      return 1'b1;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void note_item(logic is_tick, logic [7:0] b);
      parse_event_t ev;
      logic         fired;
      ev = '0;
      fired = 1'b0;
      if (is_tick) begin
        if (watch_count != 0) begin
          watch_count = watch_count - 1;
          if (watch_count == 0) begin
            pstate = ST_IDLE;
            ev.kind = KIND_TIMEOUT;
            fired = 1'b1;
          end
        end
      end else begin
        case (pstate)
          ST_IDLE:  pstate = (b == SYNC_A) ? ST_SYNC1 : ST_IDLE;
          ST_SYNC1: pstate = (b == SYNC_B) ? ST_SYNC2 : ST_IDLE;
          ST_SYNC2: pstate = (b == CLASS_NAV) ? ST_CLASS : ST_IDLE;
          ST_CLASS: begin
            pstate = ST_LEN1;
            case (b)
              ID_POS:  cur_type = TYPE_POS;
              ID_SOL:  cur_type = TYPE_SOL;
              ID_VEL:  cur_type = TYPE_VEL;
              default: pstate = ST_IDLE;
            endcase
            if (pstate == ST_LEN1) begin
              sum_a = CLASS_NAV + b;
              sum_b = CLASS_NAV + sum_a;
            end
          end
          ST_LEN1: begin
            bytes_left = {8'h00, b};
            fold_checksum(b);
            pstate = ST_LEN2;
          end
          ST_LEN2: begin
            bytes_left[15:8] = b;
            fold_checksum(b);
            if (status[cur_type] == TS_NEW) begin
              // previous copy not consumed yet
              ev.snapshot_ready = take_snapshot();
              ev.kind = KIND_DROPPED;
              ev.msg_type = cur_type;
              fired = 1'b1;
              pstate = ST_IDLE;
            end else begin
              status[cur_type] = TS_INVALID;
              write_pos = '0;
              pstate = (bytes_left == 0) ? ST_CKA : ST_DATA;
            end
          end
          ST_DATA: begin
            if (write_pos < store_limit[cur_type]) begin
              ev.kind = KIND_WRITE;
              ev.msg_type = cur_type;
              ev.byte_offset = write_pos;
              ev.data_byte = b;
              fired = 1'b1;
              write_pos = write_pos + 1;
            end
            fold_checksum(b);
            bytes_left = bytes_left - 1;
            if (bytes_left == 0) pstate = ST_CKA;
          end
          ST_CKA: begin
            if (b == sum_a) begin
              pstate = ST_CKB;
            end else begin
              status[cur_type] = TS_INVALID;
              pstate = ST_IDLE;
              ev.kind = KIND_BAD_CK;
              ev.msg_type = cur_type;
              fired = 1'b1;
            end
          end
          ST_CKB: begin
            pstate = ST_IDLE;
            ev.msg_type = cur_type;
            fired = 1'b1;
            if (b == sum_b) begin
              status[cur_type] = TS_NEW;
              ev.snapshot_ready = take_snapshot();
              watch_count = reload;
              ev.kind = KIND_GOOD;
            end else begin
              status[cur_type] = TS_INVALID;
              ev.kind = KIND_BAD_CK;
            end
          end
          default: pstate = ST_IDLE;
        endcase
      end
      if (fired) begin
        ev.new_mask = fresh_mask();
        expected_events.push_back(ev);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("%s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [1:0] mtype, logic [5:0] offset,
                               logic [7:0] data, logic snap, logic [2:0] mask);
      parse_event_t want;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("result with nothing expected: kind %0d, msg_type %0d", kind, mtype);
        return;
      end
      want = expected_events.pop_front();
      compare_field("kind", want.kind, kind);
      compare_field("msg_type", want.msg_type, mtype);
      compare_field("byte_offset", want.byte_offset, offset);
      compare_field("data_byte", want.data_byte, data);
      compare_field("snapshot_ready", want.snapshot_ready, snap);
      compare_field("new_mask", want.new_mask, mask);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [1:0]  msg_type;
  logic [5:0]  byte_offset;
  logic [7:0]  data_byte;
  logic        snapshot_ready;
  logic [2:0]  new_mask;

  parser_scoreboard sb;
  int   items_sent = 0;
  bit   quiet = 1'b0;
  int   tick_pct = 0;
  int   out_hold = 0;
  int   idle_cycles = 0;
  logic [7:0] run_a, run_b;

  gnss_binary_frame_parser_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .msg_type_o      (msg_type),
    .byte_offset_o   (byte_offset),
    .data_byte_o     (data_byte),
    .snapshot_ready_o(snapshot_ready),
    .new_mask_o      (new_mask)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short pauses, now and then a long one
  function automatic int idle_span(int zero_pct);
    int r;
    r = $urandom_range(99, 0);
    if (r < zero_pct) return 0;
    if (r < zero_pct + (100 - zero_pct) * 4 / 5) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // result side: random back-pressure, and the check of every result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(kind, msg_type, byte_offset, data_byte, snapshot_ready, new_mask);
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
    end else if (out_ready && !quiet && $urandom_range(99, 0) < 12) begin
      out_ready <= 1'b0;
      out_hold <= idle_span(0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(input logic is_tick, input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    op <= is_tick;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(is_tick, b);
    items_sent++;
    gap = quiet ? 0 : idle_span(70);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  // wait out the results still in flight, plus the pipeline for silent items
  task automatic settle_outputs();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reload(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.reload = v;
  endtask

  // frame byte, possibly preceded by a tick; summed bytes feed the checksum
  task automatic put_frame_byte(input logic [7:0] b, input bit summed);
    if ($urandom_range(99, 0) < tick_pct) push_item(1'b1, 8'($urandom));
    if (summed) begin
      run_a = run_a + b;
      run_b = run_b + run_a;
    end
    push_item(1'b0, b);
  endtask

  task automatic send_header(input logic [1:0] mtype, input logic [15:0] len);
    logic [7:0] id;
    id = (mtype == TYPE_POS) ? ID_POS : (mtype == TYPE_SOL) ? ID_SOL : ID_VEL;
    run_a = '0;
    run_b = '0;
    put_frame_byte(SYNC_A, 1'b0);
    put_frame_byte(SYNC_B, 1'b0);
    put_frame_byte(CLASS_NAV, 1'b1);
    put_frame_byte(id, 1'b1);
    put_frame_byte(len[7:0], 1'b1);
    put_frame_byte(len[15:8], 1'b1);
  endtask

  task automatic send_frame(input logic [1:0] mtype, input logic [15:0] len,
                            input frame_flaw_e flaw);
    send_header(mtype, len);
    repeat (len) put_frame_byte(8'($urandom), 1'b1);
    put_frame_byte((flaw == FLAW_CKA) ? run_a ^ 8'($urandom_range(255, 1)) : run_a, 1'b0);
    put_frame_byte((flaw == FLAW_CKB) ? run_b ^ 8'($urandom_range(255, 1)) : run_b, 1'b0);
  endtask

  // header cut off at a random point by a byte that cannot continue it
  task automatic send_broken_header();
    logic [7:0] lead [3];
    logic [7:0] bad;
    int         k;
    lead = '{SYNC_A, SYNC_B, CLASS_NAV};
    k = $urandom_range(3, 0);
    for (int i = 0; i < k; i++) push_item(1'b0, lead[i]);
    bad = $urandom;
    if (k == 3) begin
      if (bad == ID_POS || bad == ID_SOL || bad == ID_VEL) bad = bad ^ 8'h80;
    end else if (bad == lead[k]) begin
      bad = bad ^ 8'h80;
    end
    push_item(1'b0, bad);
  endtask

  // huge length, up to ten payload bytes, then ticks until the watchdog fires
  task automatic abandon_frame();
    logic [15:0] len;
    len = {8'($urandom_range(255, 1)), 8'($urandom)};
    send_header(2'($urandom_range(2, 0)), len);
    repeat ($urandom_range(10, 0)) put_frame_byte(8'($urandom), 1'b1);
    while (sb.watch_count != 0) push_item(1'b1, 8'($urandom));
  endtask

  task automatic run_random(input int count);
    int          stop_at;
    int          r;
    int          n;
    logic [1:0]  mtype;
    logic [15:0] len;
    frame_flaw_e flaw;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(99, 0);
      if (r < 70) begin
        mtype = 2'($urandom_range(2, 0));
        n = $urandom_range(99, 0);
        if (n < 55) len = $urandom_range(sb.store_limit[mtype] + 4, 0);
        else if (n < 80) len = $urandom_range(71, 0);
        else len = $urandom_range(3, 0);
        n = $urandom_range(99, 0);
        flaw = (n < 80) ? FLAW_NONE : (n < 90) ? FLAW_CKA : FLAW_CKB;
        send_frame(mtype, len, flaw);
      end else if (r < 82) begin
        send_broken_header();
      end else if (r < 94 || sb.watch_count == 0 || sb.watch_count > 64) begin
        repeat ($urandom_range(5, 1)) push_item(1'b1, 8'($urandom));
      end else begin
        abandon_frame();
      end
    end
  endtask

  initial begin
    logic [15:0] reloads [5];
    logic [1:0]  long_type;
    sb = new();
    reloads = '{16'd0, 16'hFFFF, TIMEOUT_RELOAD_RST, 16'd1, 16'($urandom_range(40, 2))};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: resync paths, zero length, watchdog expiry, pending data drop
    write_reload(16'd1);
    push_item(1'b0, SYNC_A);
    push_item(1'b0, SYNC_A);
    push_item(1'b0, SYNC_B);
    push_item(1'b0, SYNC_A);
    push_item(1'b0, SYNC_B);
    push_item(1'b0, 8'h00);
    push_item(1'b0, SYNC_A);
    push_item(1'b0, SYNC_B);
    push_item(1'b0, CLASS_NAV);
    push_item(1'b0, 8'h07);
    send_frame(TYPE_VEL, 16'd0, FLAW_NONE);
    push_item(1'b1, 8'hFF);
    send_header(TYPE_VEL, 16'd0);

    tick_pct = 4;
    for (int p = 0; p < 5; p++) begin
      idle_input();
      settle_outputs();
      write_reload(reloads[p]);
      quiet = (p == 2);
      if (reloads[p] == 16'hFFFF) begin
        // one long frame to get a nonzero upper length byte through
        long_type = TYPE_POS;
        while (sb.status[long_type] == TS_NEW) long_type = long_type + 1;
        send_frame(long_type, 16'h0100 + 16'($urandom_range(15, 0)), FLAW_NONE);
      end
      run_random(230);
    end

    idle_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gbfp_pkg.sv
hdl/gbfp_in_stage.sv
hdl/gbfp_core.sv
hdl/gbfp_out_stage.sv
hdl/gnss_binary_frame_parser_unit.sv
hdl/gbfp_checker.sv
verif/testbench.sv
